>>> hdl/ardd_pkg.sv
`default_nettype none
package ardd_pkg;

    localparam int unsigned MAX_FRAME_PIXELS = 65536;

    localparam int BUDGET_W = 17;
    localparam int POS_W    = 16;
    localparam int LEN_W    = 14;
    localparam int BYTE_W   = 8;
    localparam int PHASE_W  = 3;

    localparam logic [BUDGET_W-1:0] FRAME_PIXELS_RESET = BUDGET_W'(64000);
    localparam logic [BUDGET_W-1:0] MAX_BUDGET         = BUDGET_W'(MAX_FRAME_PIXELS);

    // parse phases
    localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
    localparam logic [PHASE_W-1:0] PH_OPCODE    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_RUN_COUNT = 3'd2;
    localparam logic [PHASE_W-1:0] PH_RUN_VALUE = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DUMP      = 3'd4;
    localparam logic [PHASE_W-1:0] PH_WORD_LOW  = 3'd5;
    localparam logic [PHASE_W-1:0] PH_WORD_HIGH = 3'd6;

    // result kinds
    localparam logic [1:0] OP_PIXEL     = 2'd0;
    localparam logic [1:0] OP_FILL      = 2'd1;
    localparam logic [1:0] OP_FRAME_END = 2'd2;

    localparam logic [6:0]  SHORT_MASK = 7'h7f;
    localparam logic [14:0] LONG_MASK  = 15'h7fff;

    typedef struct packed {
        logic [1:0]        op_kind;
        logic [POS_W-1:0]  pixel_position;
        logic [LEN_W-1:0]  fill_length;
        logic [BYTE_W-1:0] pixel_value;
        logic              frame_end;
    } result_t;

endpackage
`default_nettype wire

>>> hdl/ardd_step.sv
`default_nettype none
module ardd_step (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           en,
    input  wire logic [ardd_pkg::BYTE_W-1:0]    data_byte,
    input  wire logic                           frame_start,
    input  wire logic [ardd_pkg::BUDGET_W-1:0]  frame_pixels,
    output logic                                res_valid,
    output ardd_pkg::result_t                   res
);
    import ardd_pkg::*;

    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [BUDGET_W-1:0] budget_reg, budget_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [LEN_W-1:0]    pend_reg, pend_next;
    logic [BYTE_W-1:0]   low_reg, low_next;

    // state as seen after a frame start is applied
    logic [PHASE_W-1:0]  ph_e;
    logic [BUDGET_W-1:0] bud_e;
    logic [POS_W-1:0]    pos_e;
    logic [LEN_W-1:0]    pend_e;
    logic [BYTE_W-1:0]   low_e;
    logic [BUDGET_W-1:0] clamped;

    logic [15:0]         word;
    logic [BUDGET_W-1:0] clip_n, clip_len, bud_after;
    logic [POS_W-1:0]    pos_after;

    assign clamped = (frame_pixels > MAX_BUDGET) ? MAX_BUDGET : frame_pixels;

    always_comb begin
        ph_e   = phase_reg;
        bud_e  = budget_reg;
        pos_e  = pos_reg;
        pend_e = pend_reg;
        low_e  = low_reg;
        if (frame_start) begin
            bud_e  = clamped;
            pos_e  = '0;
            pend_e = '0;
            low_e  = '0;
            ph_e   = (clamped == '0) ? PH_IDLE : PH_OPCODE;
        end
    end

    assign word = {data_byte, low_e};

    // one shared clip: run length from pending count, skip length otherwise
    always_comb begin
        if (ph_e == PH_RUN_VALUE) begin
            clip_n = BUDGET_W'(pend_e);
        end else if (ph_e == PH_WORD_HIGH) begin
            clip_n = BUDGET_W'(word[14:0] & LONG_MASK);
        end else begin
            clip_n = BUDGET_W'(data_byte[6:0] & SHORT_MASK);
        end
        clip_len  = (clip_n < bud_e) ? clip_n : bud_e;
        bud_after = bud_e - clip_len;
        pos_after = pos_e + clip_len[POS_W-1:0];
    end

    always_comb begin
        phase_next  = ph_e;
        budget_next = bud_e;
        pos_next    = pos_e;
        pend_next   = pend_e;
        low_next    = low_e;
        res_valid   = 1'b0;
        res         = '{op_kind: OP_FRAME_END, pixel_position: pos_e, fill_length: '0,
                        pixel_value: '0, frame_end: 1'b1};
        if (frame_start && clamped == '0) begin
            // empty frame: end at once, ignore the byte
            res_valid = 1'b1;
        end else begin
            case (ph_e)
                PH_OPCODE: begin
                    if (data_byte[7] == 1'b0 && data_byte != '0) begin
                        pend_next  = LEN_W'(data_byte);
                        phase_next = PH_DUMP;
                    end else if (data_byte == '0) begin
                        phase_next = PH_RUN_COUNT;
                    end else if (data_byte[6:0] != '0) begin
                        pos_next    = pos_after;
                        budget_next = bud_after;
                        if (bud_after == '0) begin
                            phase_next         = PH_IDLE;
                            res_valid          = 1'b1;
                            res.pixel_position = pos_after;
                        end
                    end else begin
                        phase_next = PH_WORD_LOW;
                    end
                end
                PH_RUN_COUNT: begin
                    pend_next  = LEN_W'(data_byte);
                    phase_next = PH_RUN_VALUE;
                end
                PH_RUN_VALUE: begin
                    pend_next  = '0;
                    phase_next = PH_OPCODE;
                    if (clip_len != '0) begin
                        res_valid   = 1'b1;
                        res.op_kind = OP_FILL;
                        res.fill_length = clip_len[LEN_W-1:0];
                        res.pixel_value = data_byte;
                        res.frame_end   = (bud_after == '0);
                        pos_next    = pos_after;
                        budget_next = bud_after;
                        if (bud_after == '0) begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_DUMP: begin
                    res_valid       = 1'b1;
                    res.op_kind     = OP_PIXEL;
                    res.fill_length = LEN_W'(1);
                    res.pixel_value = data_byte;
                    pos_next        = pos_e + POS_W'(1);
                    if (bud_e != '0) begin
                        budget_next = bud_e - BUDGET_W'(1);
                    end
                    if (pend_e != '0) begin
                        pend_next = pend_e - LEN_W'(1);
                    end
                    res.frame_end = (budget_next == '0);
                    if (budget_next == '0) begin
                        phase_next = PH_IDLE;
                        pend_next  = '0;
                    end else if (pend_next == '0) begin
                        phase_next = PH_OPCODE;
                    end
                end
                PH_WORD_LOW: begin
                    low_next   = data_byte;
                    phase_next = PH_WORD_HIGH;
                end
                PH_WORD_HIGH: begin
                    if (word == '0) begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                    end else if (word[15] == 1'b0) begin
                        pos_next    = pos_after;
                        budget_next = bud_after;
                        phase_next  = PH_OPCODE;
                        if (bud_after == '0) begin
                            phase_next         = PH_IDLE;
                            res_valid          = 1'b1;
                            res.pixel_position = pos_after;
                        end
                    end else if (word[14]) begin
                        pend_next  = word[LEN_W-1:0];
                        phase_next = PH_RUN_VALUE;
                    end else begin
                        pend_next  = word[LEN_W-1:0];
                        phase_next = (word[LEN_W-1:0] == '0) ? PH_OPCODE : PH_DUMP;
                    end
                end
                PH_IDLE: begin
                    phase_next = PH_IDLE;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            budget_reg <= '0;
            pos_reg    <= '0;
            pend_reg   <= '0;
            low_reg    <= '0;
        end else if (en) begin
            phase_reg  <= phase_next;
            budget_reg <= budget_next;
            pos_reg    <= pos_next;
            pend_reg   <= pend_next;
            low_reg    <= low_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/anim_rle_skip_dump_run_decoder.sv
`default_nettype none
// Channel  | Direction | Handshake          | Payload
// s_       | in        | s_valid / s_ready  | data_byte, frame_start
// m_       | out       | m_valid / m_ready  | op_kind, pixel_position, fill_length,
//          |           |                    | pixel_value, frame_end
// cfg_     | in        | cfg_wr_en          | frame_pixels (17 bits)
//
// One byte per cycle sustained while m_ready stays high. A byte is held in the input
// register, is decoded against the parse state and lands in the result register.
// Bytes that give no result leave no bubble.
// Reset (aresetn low, synchronous) empties both registers, sets the frame_pixels
// register to 64000 and the decoder to wait for a frame start.
// A stall on m_ready holds the result and the input register; s_ready drops
// only when both are full.
module anim_rle_skip_dump_run_decoder (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [ardd_pkg::BYTE_W-1:0]    s_data_byte,
    input  wire logic                           s_frame_start,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [1:0]                          m_op_kind,
    output logic [ardd_pkg::POS_W-1:0]          m_pixel_position,
    output logic [ardd_pkg::LEN_W-1:0]          m_fill_length,
    output logic [ardd_pkg::BYTE_W-1:0]         m_pixel_value,
    output logic                                m_frame_end,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ardd_pkg::BUDGET_W-1:0]  cfg_wr_data
);
    import ardd_pkg::*;

    logic [BUDGET_W-1:0] frame_pixels_reg;
    logic                in_valid_reg;
    logic [BYTE_W-1:0]   in_byte_reg;
    logic                in_start_reg;
    logic                out_valid_reg;
    result_t             out_reg;

    logic    advance;
    logic    step_valid;
    result_t step_res;

    // the decode stage moves when the result register is free or being drained
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    ardd_step u_step (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (in_valid_reg && advance),
        .data_byte    (in_byte_reg),
        .frame_start  (in_start_reg),
        .frame_pixels (frame_pixels_reg),
        .res_valid    (step_valid),
        .res          (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_pixels_reg <= FRAME_PIXELS_RESET;
        end else if (cfg_wr_en) begin
            frame_pixels_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg  <= s_data_byte;
            in_start_reg <= s_frame_start;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg && step_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg && step_valid) begin
            out_reg <= step_res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_op_kind        = out_reg.op_kind;
    assign m_pixel_position = out_reg.pixel_position;
    assign m_fill_length    = out_reg.fill_length;
    assign m_pixel_value    = out_reg.pixel_value;
    assign m_frame_end      = out_reg.frame_end;

endmodule
`default_nettype wire
